// ===== sv/jps_pkg.sv =====
// Shared types and constants for the Jacobi five-point stencil sweep.
package jps_pkg;

	localparam int VAL_W      = 32;
	localparam int WGT_W      = 32;
	localparam int PROD_W     = VAL_W + WGT_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int FRAC_SHIFT = 30;
	localparam int SH_W       = ACC_W - FRAC_SHIFT;
	localparam int N_TAPS     = 5;
	localparam int ROW_LEN_W  = 7;
	localparam int CFG_IDX_W  = 3;

	// Operand slots of the multiply-accumulate chain
	localparam int TAP_WEST  = 0;
	localparam int TAP_EAST  = 1;
	localparam int TAP_NORTH = 2;
	localparam int TAP_SOUTH = 3;
	localparam int TAP_SRC   = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SRC = 3'd3;

	localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET    = 7'd64;
	localparam logic [WGT_W-1:0]     WEIGHT_EW_RESET  = 32'd268435456;
	localparam logic [WGT_W-1:0]     WEIGHT_NS_RESET  = 32'd268435456;
	localparam logic [WGT_W-1:0]     WEIGHT_SRC_RESET = 32'd0;

	// Half an output LSB, seeded into the head of the accumulate chain
	localparam logic signed [ACC_W-1:0] ROUND_CONST =
		{{(ACC_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_LATER  = 3'b100
	} row_phase_t;

	typedef struct packed {
		logic [N_TAPS-1:0][VAL_W-1:0] ops;
		logic [VAL_W-1:0]             center;
		logic                         last;
		logic                         compute;
	} lane_t;

	typedef struct packed {
		lane_t lane;
		logic  emit;
	} front_t;

	typedef struct packed {
		logic adv_prod;
		logic adv_sum;
	} cell_ctl_t;

endpackage

// ===== sv/jps_line_buf.sv =====
// Row line buffers, column and row tracking, and stencil operand fetch.
module jps_line_buf #(
	parameter int MAX_ROW_LEN = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [jps_pkg::VAL_W-1:0]         cur_value,
	input  logic [jps_pkg::VAL_W-1:0]         cur_source,
	input  logic                              cur_eog,
	input  logic [jps_pkg::ROW_LEN_W-1:0]     row_len,
	output jps_pkg::front_t                   front
);
	import jps_pkg::*;

	localparam int IDX_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int LW    = ($clog2(MAX_ROW_LEN + 1) > ROW_LEN_W) ?
		$clog2(MAX_ROW_LEN + 1) : ROW_LEN_W;
	localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(MAX_ROW_LEN - 1);

	logic [VAL_W-1:0] prev_mem  [MAX_ROW_LEN];
	logic [VAL_W-1:0] prev2_mem [MAX_ROW_LEN];
	logic [VAL_W-1:0] src_mem   [MAX_ROW_LEN];

	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] col_nxt;
	logic [IDX_W-1:0] east_addr;
	row_phase_t       phase_q;
	logic [VAL_W-1:0] rd_center_q;
	logic [VAL_W-1:0] rd_east_q;
	logic [VAL_W-1:0] rd_north_q;
	logic [VAL_W-1:0] rd_src_q;
	logic [VAL_W-1:0] west_q;
	logic [LW-1:0]    len_raw;
	logic [LW-1:0]    len_eff;
	logic             last;

	// Clamp the row length into the supported range
	always_comb begin
		len_raw = LW'(row_len);
		if (len_raw < LW'(3)) begin
			len_eff = LW'(3);
		end else if (len_raw > LW'(MAX_ROW_LEN)) begin
			len_eff = LW'(MAX_ROW_LEN);
		end else begin
			len_eff = len_raw;
		end
	end

	assign last = LW'(col_q) >= (len_eff - LW'(1));

	always_comb begin
		col_nxt = col_q;
		if (accept) begin
			if (cur_eog || last) begin
				col_nxt = '0;
			end else begin
				col_nxt = col_q + IDX_W'(1);
			end
		end
	end

	assign east_addr = (col_nxt == COL_LAST) ? '0 : col_nxt + IDX_W'(1);

	// Write the current column, prefetch the next one with write-first bypass
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_mem[col_q]  <= cur_value;
			prev2_mem[col_q] <= rd_center_q;
			src_mem[col_q]   <= cur_source;
		end
		rd_center_q <= (accept && col_q == col_nxt) ? cur_value : prev_mem[col_nxt];
		rd_east_q   <= (accept && col_q == east_addr) ? cur_value : prev_mem[east_addr];
		rd_north_q  <= (accept && col_q == col_nxt) ? rd_center_q : prev2_mem[col_nxt];
		rd_src_q    <= (accept && col_q == col_nxt) ? cur_source : src_mem[col_nxt];
	end

	// Center of the previous column becomes the west neighbor
	always_ff @(posedge clk) begin
		if (accept) begin
			west_q <= rd_center_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= PH_FIRST;
		end else if (accept) begin
			col_q <= col_nxt;
			if (cur_eog) begin
				phase_q <= PH_FIRST;
			end else if (last) begin
				case (phase_q)
					PH_FIRST:  phase_q <= PH_SECOND;
					PH_SECOND: phase_q <= PH_LATER;
					PH_LATER:  phase_q <= PH_LATER;
					default:   phase_q <= PH_FIRST;
				endcase
			end
		end
	end

	always_comb begin
		front.emit                   = (phase_q != PH_FIRST);
		front.lane.ops[TAP_WEST]     = west_q;
		front.lane.ops[TAP_EAST]     = rd_east_q;
		front.lane.ops[TAP_NORTH]    = rd_north_q;
		front.lane.ops[TAP_SOUTH]    = cur_value;
		front.lane.ops[TAP_SRC]      = rd_src_q;
		front.lane.center            = rd_center_q;
		front.lane.last              = last;
		front.lane.compute           = (phase_q == PH_LATER) && (col_q != '0) && !last;
	end

endmodule

// ===== sv/jps_mac_cell.sv =====
// One multiply-accumulate cell of the systolic weighted-sum chain.
module jps_mac_cell (
	input  logic                                 clk,
	input  jps_pkg::cell_ctl_t                   ctl,
	input  logic [jps_pkg::WGT_W-1:0]            weight,
	input  logic [jps_pkg::VAL_W-1:0]            op,
	input  jps_pkg::lane_t                       lane_in,
	input  logic signed [jps_pkg::ACC_W-1:0]     sum_in,
	output jps_pkg::lane_t                       lane_out,
	output logic signed [jps_pkg::ACC_W-1:0]     sum_out
);
	import jps_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	lane_t                    lane_q;
	logic signed [ACC_W-1:0]  sum_q;

	// Multiply stage: form the product, hand the lane on
	always_ff @(posedge clk) begin
		if (ctl.adv_prod) begin
			prod_q <= $signed(weight) * $signed(op);
			lane_q <= lane_in;
		end
	end

	// Accumulate stage: add to the partial sum from the upstream cell
	always_ff @(posedge clk) begin
		if (ctl.adv_sum) begin
			sum_q <= sum_in + ACC_W'(prod_q);
		end
	end

	assign lane_out = lane_q;
	assign sum_out  = sum_q;

endmodule

// ===== sv/jacobi_poisson_stencil_sweep.sv =====
// Top level of the streaming Jacobi five-point stencil sweep.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  cell     | cell_valid / cell_ready  | cell_value, source_term, end_of_grid
//  result   | result_valid/result_ready| new_value, row_done, saturated
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One grid cell is taken per cycle while cell_ready is high; the sustained rate is one cell per clock
// when the result side does not stall. A result passes through one operand stage, five chained
// multiply-accumulate cells (product and sum stages, overlapped), and a
// round-and-clamp output register. The line buffers use one write and
// registered reads per cycle, with the next column prefetched.
// Reset clears the column counter, the row phase, pipeline valids and config registers;
// line buffers and pipeline data registers are not cleared. A stall at the result side fills empty
// pipeline stages first and only then drops cell_ready. cfg_ready is always high.
module jacobi_poisson_stencil_sweep #(
	parameter int MAX_ROW_LEN = 64,
	parameter int VALUE_BITS  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cell_valid,
	output logic                                  cell_ready,
	input  logic signed [jps_pkg::VAL_W-1:0]      cell_value,
	input  logic signed [jps_pkg::VAL_W-1:0]      source_term,
	input  logic                                  end_of_grid,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [jps_pkg::VAL_W-1:0]      new_value,
	output logic                                  row_done,
	output logic                                  saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [jps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [jps_pkg::WGT_W-1:0]             cfg_data
);
	import jps_pkg::*;

	localparam int NSTG     = N_TAPS + 3;
	localparam int SAT_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic signed [SH_W-1:0] SAT_MAX =
		SH_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [SH_W-1:0] SAT_MIN =
		SH_W'(-(64'sd1 <<< (SAT_BITS - 1)));

	// Configuration registers
	logic [ROW_LEN_W-1:0] row_len_q;
	logic [WGT_W-1:0]     weight_ew_q;
	logic [WGT_W-1:0]     weight_ns_q;
	logic [WGT_W-1:0]     weight_src_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q    <= ROW_LEN_RESET;
			weight_ew_q  <= WEIGHT_EW_RESET;
			weight_ns_q  <= WEIGHT_NS_RESET;
			weight_src_q <= WEIGHT_SRC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_LEN:    row_len_q    <= cfg_data[ROW_LEN_W-1:0];
				REG_WEIGHT_EW:  weight_ew_q  <= cfg_data;
				REG_WEIGHT_NS:  weight_ns_q  <= cfg_data;
				REG_WEIGHT_SRC: weight_src_q <= cfg_data;
				default:        ; // drop writes beyond the register list
			endcase
		end
	end

	// Pipeline occupancy and backpressure: stage s advances when it is
	// empty or its successor advances.
	logic [NSTG:1] v_q;
	logic [NSTG:1] rdy;
	logic          cell_acc;
	front_t        front;

	always_comb begin
		rdy[NSTG] = !v_q[NSTG] || result_ready;
		for (int s = NSTG - 1; s >= 1; s--) begin
			rdy[s] = !v_q[s] || rdy[s+1];
		end
	end

	assign cell_ready = rdy[1];
	assign cell_acc   = cell_valid && cell_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= cell_acc && front.emit;
			end
			for (int s = 2; s <= NSTG; s++) begin
				if (rdy[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
		end
	end

	jps_line_buf #(
		.MAX_ROW_LEN(MAX_ROW_LEN)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (cell_acc),
		.cur_value (cell_value),
		.cur_source(source_term),
		.cur_eog   (end_of_grid),
		.row_len   (row_len_q),
		.front     (front)
	);

	// Operand stage
	lane_t lane_s1;

	always_ff @(posedge clk) begin
		if (rdy[1] && cell_acc) begin
			lane_s1 <= front.lane;
		end
	end

	// Weight for each tap of the chain
	logic [WGT_W-1:0] tap_wgt [N_TAPS];

	always_comb begin
		tap_wgt[TAP_WEST]  = weight_ew_q;
		tap_wgt[TAP_EAST]  = weight_ew_q;
		tap_wgt[TAP_NORTH] = weight_ns_q;
		tap_wgt[TAP_SOUTH] = weight_ns_q;
		tap_wgt[TAP_SRC]   = weight_src_q;
	end

	// Chain of MAC cells: cell k multiplies in stage k+2 and sums in stage k+3
	lane_t                   lane_c [N_TAPS+1];
	logic signed [ACC_W-1:0] sum_c  [N_TAPS+1];

	assign lane_c[0] = lane_s1;
	assign sum_c[0]  = ROUND_CONST;

	for (genvar k = 0; k < N_TAPS; k++) begin : g_cell
		cell_ctl_t ctl;

		assign ctl = '{adv_prod: rdy[k+2] && v_q[k+1], adv_sum: rdy[k+3] && v_q[k+2]};

		jps_mac_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.weight  (tap_wgt[k]),
			.op      (lane_c[k].ops[k]),
			.lane_in (lane_c[k]),
			.sum_in  (sum_c[k]),
			.lane_out(lane_c[k+1]),
			.sum_out (sum_c[k+1])
		);
	end

	// Side data aligned with the last sum
	logic [VAL_W-1:0] center_s7;
	logic             last_s7;
	logic             compute_s7;

	always_ff @(posedge clk) begin
		if (rdy[NSTG-1] && v_q[NSTG-2]) begin
			center_s7  <= lane_c[N_TAPS].center;
			last_s7    <= lane_c[N_TAPS].last;
			compute_s7 <= lane_c[N_TAPS].compute;
		end
	end

	// Round (seeded above), shift out the Q2.30 weight fraction and clamp
	logic signed [SH_W-1:0] shifted;
	logic signed [SH_W-1:0] clamped;
	logic                   clip;

	assign shifted = $signed(sum_c[N_TAPS][ACC_W-1:FRAC_SHIFT]);

	always_comb begin
		clip    = 1'b0;
		clamped = shifted;
		if (shifted > SAT_MAX) begin
			clamped = SAT_MAX;
			clip    = 1'b1;
		end else if (shifted < SAT_MIN) begin
			clamped = SAT_MIN;
			clip    = 1'b1;
		end
	end

	// Output register
	logic [VAL_W-1:0] new_value_s8;
	logic             row_done_s8;
	logic             saturated_s8;

	always_ff @(posedge clk) begin
		if (rdy[NSTG] && v_q[NSTG-1]) begin
			new_value_s8 <= compute_s7 ? clamped[VAL_W-1:0] : center_s7;
			row_done_s8  <= last_s7;
			saturated_s8 <= compute_s7 && clip;
		end
	end

	assign result_valid = v_q[NSTG];
	assign new_value    = $signed(new_value_s8);
	assign row_done     = row_done_s8;
	assign saturated    = saturated_s8;

endmodule
